FILE: src/hcr_pkg.sv
// shared types and constants of the headset command responder
`timescale 1ns / 1ps
`default_nettype none
package hcr_pkg;

   localparam int MAX_LEN = 10;
   localparam int DEF_QUEUE_DEPTH = 2;

   // opcodes
   localparam logic [7:0] OP_INIT          = 8'h00;
   localparam logic [7:0] OP_FW_GET        = 8'h04;
   localparam logic [7:0] OP_BATT_GET      = 8'h10;
   localparam logic [7:0] OP_CAP_GET       = 8'h12;
   localparam logic [7:0] OP_CODEC_GET     = 8'h18;
   localparam logic [7:0] OP_BATT2_GET     = 8'h22;
   localparam logic [7:0] OP_POWER_SET     = 8'h24;
   localparam logic [7:0] OP_AUTO_OFF_GET  = 8'h26;
   localparam logic [7:0] OP_AUTO_OFF_SET  = 8'h28;
   localparam logic [7:0] OP_EQ_GET        = 8'h56;
   localparam logic [7:0] OP_EQ_SET        = 8'h58;
   localparam logic [7:0] OP_NOISE_GET     = 8'h66;
   localparam logic [7:0] OP_NOISE_SET     = 8'h68;
   localparam logic [7:0] OP_DSEE_GET      = 8'he6;
   localparam logic [7:0] OP_DSEE_SET      = 8'he8;
   localparam logic [7:0] OP_MISC_GET      = 8'hf6;
   localparam logic [7:0] OP_MISC_SET      = 8'hf8;

   // subtypes
   localparam logic [7:0] ST_NONE     = 8'h00;
   localparam logic [7:0] ST_ONE      = 8'h01;
   localparam logic [7:0] ST_TWO      = 8'h02;
   localparam logic [7:0] ST_POWER    = 8'h03;
   localparam logic [7:0] ST_AUTO_OFF = 8'h05;
   localparam logic [7:0] ST_EARBUDS  = 8'h09;
   localparam logic [7:0] ST_CASE     = 8'h0a;
   localparam logic [7:0] ST_STC      = 8'h0c;
   localparam logic [7:0] ST_NOISE    = 8'h17;

   localparam logic [7:0] EQ_BAND_COUNT = 8'h06;
   localparam logic [7:0] CAP_CODE      = 8'h10;
   localparam logic [39:0] FW_VERSION   = "2.3.1";

   // register indexes
   localparam logic [2:0] REG_EARBUDS  = 3'd0;
   localparam logic [2:0] REG_LEGACY   = 3'd1;
   localparam logic [2:0] REG_BATTERY  = 3'd2;
   localparam logic [2:0] REG_CHARGING = 3'd3;
   localparam logic [2:0] REG_LEFT     = 3'd4;
   localparam logic [2:0] REG_RIGHT    = 3'd5;
   localparam logic [2:0] REG_CASE     = 3'd6;

   typedef struct packed {
      logic       earbuds_mode;
      logic       legacy_v1_mode;
      logic [6:0] battery_level;
      logic       charging_flag;
      logic [6:0] left_battery;
      logic [6:0] right_battery;
      logic [6:0] case_battery;
   } cfg_type;

   typedef struct packed {
      logic [MAX_LEN-1:0][7:0] bytes;
      logic [3:0]              count;
      logic                    seq;
      logic                    power_off;
   } entry_type;

endpackage
`default_nettype wire

FILE: src/hcr_front.sv
// front end: accepts requests, updates settings and builds reply entries
`timescale 1ns / 1ps
`default_nettype none
module hcr_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire hcr_pkg::cfg_type   cfg,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_func,
   input  wire logic [7:0]         req_subtype,
   input  wire logic [3:0]         req_arg_count,
   input  wire logic [7:0]         req_arg2,
   input  wire logic [7:0]         req_arg3,
   input  wire logic [7:0]         req_arg4,
   input  wire logic [7:0]         req_arg5,
   input  wire logic [7:0]         req_arg6,
   input  wire logic [7:0]         req_arg7,
   input  wire logic [7:0]         req_arg8,
   input  wire logic [7:0]         req_arg9,
   input  wire logic               queue_full,
   output logic                    push,
   output hcr_pkg::entry_type      push_entry
);
   import hcr_pkg::*;

   logic [3:0][7:0] noise_ff, noise_in;
   logic [7:0]      eq_preset_ff, eq_preset_in;
   logic [5:0][7:0] eq_band_ff, eq_band_in;
   logic            dsee_ff, dsee_in;
   logic [1:0][7:0] auto_off_ff, auto_off_in;
   logic            stc_ff, stc_in;
   logic            av_ff, av_in;
   logic            seq_ff, seq_in;

   logic                    accept;
   logic [3:0]              len;
   logic [7:0]              typ;
   logic [MAX_LEN-1:0][7:0] rb;
   logic [3:0]              cnt;
   logic                    emit;
   logic                    pwr;

   assign req_ready = !queue_full;
   assign accept    = req_valid && !queue_full;
   assign len       = (req_arg_count > 4'd10) ? 4'd10 : req_arg_count;
   assign typ       = (len > 4'd1) ? req_subtype : ST_NONE;

   always_comb begin
      noise_in    = noise_ff;
      eq_preset_in = eq_preset_ff;
      eq_band_in  = eq_band_ff;
      dsee_in     = dsee_ff;
      auto_off_in = auto_off_ff;
      stc_in      = stc_ff;
      av_in       = av_ff;
      rb          = '0;
      cnt         = 4'd0;
      emit        = 1'b0;
      pwr         = 1'b0;
      if (len != 4'd0) begin
         unique case (req_func)
            OP_INIT: begin
               rb[0] = 8'h01; rb[1] = 8'h00; cnt = 4'd2; emit = 1'b1;
            end
            OP_FW_GET: begin
               if (typ == ST_TWO) begin
                  rb[0] = 8'h05; rb[1] = ST_TWO; rb[2] = 8'h05;
                  rb[3] = FW_VERSION[39:32]; rb[4] = FW_VERSION[31:24];
                  rb[5] = FW_VERSION[23:16]; rb[6] = FW_VERSION[15:8];
                  rb[7] = FW_VERSION[7:0];
                  cnt = 4'd8; emit = 1'b1;
               end
            end
            OP_CAP_GET: begin
               if (typ == ST_TWO) begin
                  rb[0] = 8'h13; rb[1] = ST_TWO; rb[2] = CAP_CODE;
                  cnt = 4'd3; emit = 1'b1;
               end
            end
            OP_CODEC_GET: begin
               if (typ == ST_NONE) begin
                  rb[0] = 8'h19; rb[1] = ST_NONE; rb[2] = CAP_CODE;
                  cnt = 4'd3; emit = 1'b1;
               end
            end
            OP_BATT_GET: begin
               if (typ == ST_NONE) begin
                  rb[0] = 8'h11; rb[1] = ST_NONE;
                  rb[2] = {1'b0, cfg.battery_level}; rb[3] = {7'd0, cfg.charging_flag};
                  cnt = 4'd4; emit = 1'b1;
               end
            end
            OP_BATT2_GET: begin
               if (cfg.legacy_v1_mode) begin
                  // legacy firmware reuses this opcode for power-off
                  if (typ == ST_NONE && len >= 4'd3 && req_arg2 == 8'h01) begin
                     pwr = 1'b1; cnt = 4'd1; emit = 1'b1;
                  end
               end else if (cfg.earbuds_mode) begin
                  if (typ == ST_EARBUDS) begin
                     rb[0] = 8'h23; rb[1] = ST_EARBUDS;
                     rb[2] = {1'b0, cfg.left_battery}; rb[3] = {7'd0, cfg.charging_flag};
                     rb[4] = {1'b0, cfg.right_battery}; rb[5] = {7'd0, cfg.charging_flag};
                     cnt = 4'd6; emit = 1'b1;
                  end else if (typ == ST_CASE) begin
                     rb[0] = 8'h23; rb[1] = ST_CASE;
                     rb[2] = {1'b0, cfg.case_battery}; rb[3] = 8'h00;
                     cnt = 4'd4; emit = 1'b1;
                  end
               end else if (typ == ST_NONE) begin
                  rb[0] = 8'h23; rb[1] = ST_NONE;
                  rb[2] = {1'b0, cfg.battery_level}; rb[3] = {7'd0, cfg.charging_flag};
                  cnt = 4'd4; emit = 1'b1;
               end
            end
            OP_NOISE_GET: begin
               if (typ == ST_NOISE) begin
                  rb[0] = 8'h67; rb[1] = ST_NOISE; rb[2] = 8'h01;
                  rb[3] = noise_ff[0]; rb[4] = noise_ff[1];
                  rb[5] = noise_ff[2]; rb[6] = noise_ff[3];
                  cnt = 4'd7; emit = 1'b1;
               end else if (typ == ST_TWO) begin
                  rb[0] = 8'h67; rb[1] = ST_TWO; rb[2] = noise_ff[0]; rb[3] = 8'h01;
                  rb[4] = (noise_ff[1] == 8'h01) ? 8'h00 : 8'h02;
                  rb[5] = 8'h01; rb[6] = noise_ff[2]; rb[7] = noise_ff[3];
                  cnt = 4'd8; emit = 1'b1;
               end
            end
            OP_NOISE_SET: begin
               if (typ == ST_NOISE && len >= 4'd7) begin
                  noise_in = {req_arg6, req_arg5, req_arg4, req_arg3};
                  rb[0] = 8'h69; rb[1] = ST_NOISE; rb[2] = 8'h01;
                  rb[3] = req_arg3; rb[4] = req_arg4; rb[5] = req_arg5; rb[6] = req_arg6;
                  cnt = 4'd7; emit = 1'b1;
               end else if (typ == ST_TWO && len >= 4'd8) begin
                  noise_in[0] = req_arg2;
                  noise_in[1] = {7'd0, (req_arg2 != 8'h00 && req_arg4 == 8'h00)};
                  noise_in[2] = req_arg6;
                  noise_in[3] = req_arg7;
               end
            end
            OP_EQ_GET: begin
               rb[0] = 8'h57; rb[1] = typ; rb[2] = eq_preset_ff; rb[3] = EQ_BAND_COUNT;
               rb[9:4] = eq_band_ff;
               cnt = 4'd10; emit = 1'b1;
            end
            OP_EQ_SET: begin
               if (len >= 4'd3) eq_preset_in = req_arg2;
               if (len == 4'd10 && req_arg3 == EQ_BAND_COUNT) begin
                  eq_band_in = {req_arg9, req_arg8, req_arg7, req_arg6, req_arg5, req_arg4};
               end
               // reply shows the values just written
               rb[0] = 8'h59; rb[1] = 8'h00; rb[2] = eq_preset_in; rb[3] = EQ_BAND_COUNT;
               rb[9:4] = eq_band_in;
               cnt = 4'd10; emit = 1'b1;
            end
            OP_DSEE_GET: begin
               if (typ == ST_ONE) begin
                  rb[0] = 8'he7; rb[1] = ST_ONE; rb[2] = {7'd0, dsee_ff};
                  cnt = 4'd3; emit = 1'b1;
               end
            end
            OP_DSEE_SET: begin
               if (typ == ST_ONE && len >= 4'd3) dsee_in = (req_arg2 != 8'h00);
            end
            OP_POWER_SET: begin
               if (typ == ST_POWER && len >= 4'd3 && req_arg2 == 8'h01) begin
                  pwr = 1'b1; cnt = 4'd1; emit = 1'b1;
               end
            end
            OP_AUTO_OFF_GET: begin
               if (typ == ST_AUTO_OFF) begin
                  rb[0] = 8'h27; rb[1] = ST_AUTO_OFF;
                  rb[2] = auto_off_ff[0]; rb[3] = auto_off_ff[1];
                  cnt = 4'd4; emit = 1'b1;
               end
            end
            OP_AUTO_OFF_SET: begin
               if (typ == ST_AUTO_OFF && len >= 4'd4) auto_off_in = {req_arg3, req_arg2};
            end
            OP_MISC_GET: begin
               if (typ == ST_STC) begin
                  rb[0] = 8'hf7; rb[1] = ST_STC; rb[2] = {7'd0, !stc_ff};
                  cnt = 4'd3; emit = 1'b1;
               end else if (typ == ST_CASE) begin
                  rb[0] = 8'hf7; rb[1] = ST_CASE; rb[2] = {7'd0, !av_ff};
                  cnt = 4'd3; emit = 1'b1;
               end
            end
            OP_MISC_SET: begin
               if (len >= 4'd3) begin
                  if (typ == ST_STC) stc_in = (req_arg2 == 8'h00);
                  if (typ == ST_CASE) av_in = (req_arg2 == 8'h00);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // power-off events carry fixed fields and leave the sequence bit alone
   always_comb begin
      push_entry.bytes     = rb;
      push_entry.count     = cnt;
      push_entry.seq       = pwr ? 1'b0 : seq_ff;
      push_entry.power_off = pwr;
      push                 = accept && emit;
      seq_in               = seq_ff ^ (accept && emit && !pwr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_ff     <= '0;
         eq_preset_ff <= '0;
         eq_band_ff   <= '0;
         dsee_ff      <= 1'b0;
         auto_off_ff  <= '0;
         stc_ff       <= 1'b0;
         av_ff        <= 1'b0;
         seq_ff       <= 1'b0;
      end else if (accept) begin
         noise_ff     <= noise_in;
         eq_preset_ff <= eq_preset_in;
         eq_band_ff   <= eq_band_in;
         dsee_ff      <= dsee_in;
         auto_off_ff  <= auto_off_in;
         stc_ff       <= stc_in;
         av_ff        <= av_in;
         seq_ff       <= seq_in;
      end
   end

   property p_no_push_when_full;
      @(posedge clock) disable iff (reset) queue_full |-> !push;
   endproperty
   a_no_push_when_full: assert property (p_no_push_when_full)
      else $error("entry pushed into a full queue");

   property p_event_single;
      @(posedge clock) disable iff (reset)
         push && push_entry.power_off |-> push_entry.count == 4'd1;
   endproperty
   a_event_single: assert property (p_event_single)
      else $error("power-off event with more than one result");

   property p_seq_toggle;
      @(posedge clock) disable iff (reset)
         push && !push_entry.power_off |=> seq_ff != $past(seq_ff);
   endproperty
   a_seq_toggle: assert property (p_seq_toggle)
      else $error("sequence bit did not toggle after a reply");

endmodule
`default_nettype wire

FILE: src/hcr_queue.sv
// short queue of reply entries between front and back
`timescale 1ns / 1ps
`default_nettype none
module hcr_queue #(
   parameter int Depth = hcr_pkg::DEF_QUEUE_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire hcr_pkg::entry_type  push_entry,
   output logic                     full,
   output logic                     head_valid,
   output hcr_pkg::entry_type       head,
   input  wire logic                pop
);
   import hcr_pkg::*;

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   entry_type       mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full       = (count_ff == CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_entry;
   end

   property p_no_pop_empty;
      @(posedge clock) disable iff (reset) pop |-> head_valid;
   endproperty
   a_no_pop_empty: assert property (p_no_pop_empty)
      else $error("pop from an empty queue");

   property p_count_bound;
      @(posedge clock) disable iff (reset) count_ff <= CntW'(Depth);
   endproperty
   a_count_bound: assert property (p_count_bound)
      else $error("queue count above depth");

   property p_count_step;
      @(posedge clock) disable iff (reset)
         push && !pop |=> count_ff == $past(count_ff) + 1'b1;
   endproperty
   a_count_step: assert property (p_count_step)
      else $error("queue count did not follow a push");

endmodule
`default_nettype wire

FILE: src/hcr_back.sv
// back end: drains queued replies one byte per cycle into the output register while rsp_ready does not stall it
`timescale 1ns / 1ps
`default_nettype none
module hcr_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                head_valid,
   input  wire hcr_pkg::entry_type  head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [7:0]               rsp_reply_byte,
   output logic                     rsp_reply_last,
   output logic                     rsp_reply_sequence,
   output logic                     rsp_power_off
);
   import hcr_pkg::*;

   logic       valid_ff, valid_in;
   logic [3:0] idx_ff, idx_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       seq_ff, seq_in;
   logic       pwr_ff, pwr_in;
   logic       advance;
   logic       load;
   logic       is_last;

   assign advance = !valid_ff || rsp_ready;
   assign load    = advance && head_valid;
   assign is_last = (idx_ff == head.count - 4'd1);
   assign pop     = load && is_last;

   always_comb begin
      valid_in = advance ? head_valid : valid_ff;
      idx_in   = idx_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      seq_in   = seq_ff;
      pwr_in   = pwr_ff;
      if (load) begin
         byte_in = head.bytes[idx_ff];
         last_in = is_last;
         seq_in  = head.seq;
         pwr_in  = head.power_off;
         idx_in  = is_last ? 4'd0 : idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 4'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      seq_ff  <= seq_in;
      pwr_ff  <= pwr_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_reply_byte     = byte_ff;
   assign rsp_reply_last     = last_ff;
   assign rsp_reply_sequence = seq_ff;
   assign rsp_power_off      = pwr_ff;

   property p_event_fields;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_power_off |->
            rsp_reply_last && rsp_reply_byte == 8'h00 && !rsp_reply_sequence;
   endproperty
   a_event_fields: assert property (p_event_fields)
      else $error("power-off event with reply fields set");

   property p_idx_in_range;
      @(posedge clock) disable iff (reset) head_valid |-> idx_ff < head.count;
   endproperty
   a_idx_in_range: assert property (p_idx_in_range)
      else $error("byte index past the reply length");

   property p_reply_continues;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_ready && !rsp_reply_last |=>
            rsp_valid && !rsp_power_off && rsp_reply_sequence == $past(rsp_reply_sequence);
   endproperty
   a_reply_continues: assert property (p_reply_continues)
      else $error("reply broken before its last byte");

endmodule
`default_nettype wire

FILE: src/headset_command_responder_unit.sv
// top level of the headset command responder
//
// req_ channel: one decoded command per request (opcode, subtype, length and
// argument bytes). rsp_ channel: the reply payload, one byte per transfer,
// with a last mark and the reply sequence bit; a power-off command gives a
// single transfer with rsp_power_off set. csr_ port: APB-style registers for
// the battery report and the earbuds and legacy modes, pready tied high.
// The front decodes a request and updates the settings in the cycle it is
// accepted, then drops the reply into a small queue (QueueDepth entries).
// The back reads the queue head and loads the output register one byte per
// cycle while rsp_ready or an empty output lets it; a request's first byte
// passes through the queue and then the output register. Requests are taken
// one per cycle while the queue has room; the back sends an n-byte reply
// (n from 1 to 10) one byte per transfer, so sustained rate is set by reply
// length. Requests with no reply never enter the queue.
// Reset is synchronous: settings and the sequence bit clear, battery
// registers go to 100, queue and output empty. No clearing pass is needed.
// A stalled rsp_ready holds the output register; the queue then fills and
// req_ready drops.
`timescale 1ns / 1ps
`default_nettype none
module headset_command_responder_unit #(
   parameter int QueueDepth = hcr_pkg::DEF_QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_func,
   input  wire logic [7:0]  req_subtype,
   input  wire logic [3:0]  req_arg_count,
   input  wire logic [7:0]  req_arg2,
   input  wire logic [7:0]  req_arg3,
   input  wire logic [7:0]  req_arg4,
   input  wire logic [7:0]  req_arg5,
   input  wire logic [7:0]  req_arg6,
   input  wire logic [7:0]  req_arg7,
   input  wire logic [7:0]  req_arg8,
   input  wire logic [7:0]  req_arg9,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_reply_byte,
   output logic             rsp_reply_last,
   output logic             rsp_reply_sequence,
   output logic             rsp_power_off,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import hcr_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       csr_write;
   logic [2:0] reg_idx;
   logic       queue_full;
   logic       push;
   entry_type  push_entry;
   logic       head_valid;
   entry_type  head;
   logic       pop;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_idx)
            REG_EARBUDS:  cfg_in.earbuds_mode   = csr_pwdata[0];
            REG_LEGACY:   cfg_in.legacy_v1_mode = csr_pwdata[0];
            REG_BATTERY:  cfg_in.battery_level  = csr_pwdata[6:0];
            REG_CHARGING: cfg_in.charging_flag  = csr_pwdata[0];
            REG_LEFT:     cfg_in.left_battery   = csr_pwdata[6:0];
            REG_RIGHT:    cfg_in.right_battery  = csr_pwdata[6:0];
            REG_CASE:     cfg_in.case_battery   = csr_pwdata[6:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_EARBUDS:  csr_prdata = {31'd0, cfg_ff.earbuds_mode};
         REG_LEGACY:   csr_prdata = {31'd0, cfg_ff.legacy_v1_mode};
         REG_BATTERY:  csr_prdata = {25'd0, cfg_ff.battery_level};
         REG_CHARGING: csr_prdata = {31'd0, cfg_ff.charging_flag};
         REG_LEFT:     csr_prdata = {25'd0, cfg_ff.left_battery};
         REG_RIGHT:    csr_prdata = {25'd0, cfg_ff.right_battery};
         REG_CASE:     csr_prdata = {25'd0, cfg_ff.case_battery};
         default:      csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.earbuds_mode   <= 1'b0;
         cfg_ff.legacy_v1_mode <= 1'b0;
         cfg_ff.battery_level  <= 7'd100;
         cfg_ff.charging_flag  <= 1'b0;
         cfg_ff.left_battery   <= 7'd100;
         cfg_ff.right_battery  <= 7'd100;
         cfg_ff.case_battery   <= 7'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hcr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_subtype   (req_subtype),
      .req_arg_count (req_arg_count),
      .req_arg2      (req_arg2),
      .req_arg3      (req_arg3),
      .req_arg4      (req_arg4),
      .req_arg5      (req_arg5),
      .req_arg6      (req_arg6),
      .req_arg7      (req_arg7),
      .req_arg8      (req_arg8),
      .req_arg9      (req_arg9),
      .queue_full    (queue_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   hcr_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   hcr_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_reply_byte     (rsp_reply_byte),
      .rsp_reply_last     (rsp_reply_last),
      .rsp_reply_sequence (rsp_reply_sequence),
      .rsp_power_off      (rsp_power_off)
   );

endmodule
`default_nettype wire

FILE: bench/headset_command_responder_unit_test.sv
// testbench of the headset command responder: random and directed commands against a predictor
`timescale 1ns / 1ps
module headset_command_responder_unit_test;
   import hcr_pkg::*;

   localparam logic [7:0] OP_UNUSED   = 8'hff;
   localparam logic [7:0] ST_UNUSED   = 8'hff;
   localparam logic [7:0] ARG_ON      = 8'h01;
   localparam logic [7:0] FW_TEXT_LEN = 8'd5;

   typedef struct packed {
      logic [7:0]      func;
      logic [7:0]      subtype;
      logic [3:0]      arg_count;
      logic [2:9][7:0] arg;
   } command_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       seq;
      logic       power_off;
   } reply_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_func = '0;
   logic [7:0]  req_subtype = '0;
   logic [3:0]  req_arg_count = '0;
   logic [7:0]  req_arg2 = '0;
   logic [7:0]  req_arg3 = '0;
   logic [7:0]  req_arg4 = '0;
   logic [7:0]  req_arg5 = '0;
   logic [7:0]  req_arg6 = '0;
   logic [7:0]  req_arg7 = '0;
   logic [7:0]  req_arg8 = '0;
   logic [7:0]  req_arg9 = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_reply_byte;
   logic        rsp_reply_last;
   logic        rsp_reply_sequence;
   logic        rsp_power_off;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   headset_command_responder_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_subtype(req_subtype),
      .req_arg_count(req_arg_count),
      .req_arg2(req_arg2),
      .req_arg3(req_arg3),
      .req_arg4(req_arg4),
      .req_arg5(req_arg5),
      .req_arg6(req_arg6),
      .req_arg7(req_arg7),
      .req_arg8(req_arg8),
      .req_arg9(req_arg9),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_reply_byte(rsp_reply_byte),
      .rsp_reply_last(rsp_reply_last),
      .rsp_reply_sequence(rsp_reply_sequence),
      .rsp_power_off(rsp_power_off),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predicted headset settings and register copy
   cfg_type    settings;
   logic [7:0] noise_mode [0:3];
   logic [7:0] eq_preset;
   logic [7:0] eq_bands [0:5];
   logic       dsee_enabled;
   logic [7:0] auto_off [0:1];
   logic       chat_enabled;
   logic       adaptive_enabled;
   logic       reply_seq;

   command_type    pending [$];
   reply_beat_type replies_due [$];
   int requests_sent = 0;
   int requests_taken = 0;
   int error_count = 0;
   int hold_left = 0;
   int stall_left = 0;
   bit req_accepted = 0;
   bit req_idling = 0;
   bit rsp_idling = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   function automatic command_type command(input logic [7:0] func, input logic [7:0] subtype,
                                           input logic [3:0] count, input logic [63:0] args);
      command_type c;
      c.func = func;
      c.subtype = subtype;
      c.arg_count = count;
      c.arg = args;
      return c;
   endfunction

   function automatic logic [7:0] pick_opcode();
      case ($urandom_range(0, 16))
         0: return OP_INIT;
         1: return OP_FW_GET;
         2: return OP_BATT_GET;
         3: return OP_CAP_GET;
         4: return OP_CODEC_GET;
         5: return OP_BATT2_GET;
         6: return OP_POWER_SET;
         7: return OP_AUTO_OFF_GET;
         8: return OP_AUTO_OFF_SET;
         9: return OP_EQ_GET;
         10: return OP_EQ_SET;
         11: return OP_NOISE_GET;
         12: return OP_NOISE_SET;
         13: return OP_DSEE_GET;
         14: return OP_DSEE_SET;
         15: return OP_MISC_GET;
         default: return OP_MISC_SET;
      endcase
   endfunction

   function automatic logic [7:0] usual_subtype(input logic [7:0] op);
      case (op)
         OP_FW_GET, OP_CAP_GET: return ST_TWO;
         OP_POWER_SET: return ST_POWER;
         OP_AUTO_OFF_GET, OP_AUTO_OFF_SET: return ST_AUTO_OFF;
         OP_DSEE_GET, OP_DSEE_SET: return ST_ONE;
         OP_NOISE_GET, OP_NOISE_SET: return $urandom_range(0, 1) ? ST_NOISE : ST_TWO;
         OP_MISC_GET, OP_MISC_SET: return $urandom_range(0, 1) ? ST_STC : ST_CASE;
         OP_EQ_GET, OP_EQ_SET: return 8'($urandom_range(0, 255));
         OP_BATT2_GET: begin
            case ($urandom_range(0, 2))
               0: return ST_NONE;
               1: return ST_EARBUDS;
               default: return ST_CASE;
            endcase
         end
         default: return ST_NONE;
      endcase
   endfunction

   // mostly well-formed commands with random content, some garbage opcodes and subtypes
   function automatic command_type random_command();
      command_type c;
      int r;
      int k;
      c.func = pick_opcode();
      if ($urandom_range(0, 99) < 8) c.func = 8'($urandom_range(0, 255));
      c.subtype = usual_subtype(c.func);
      if ($urandom_range(0, 99) < 10) c.subtype = 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 55) c.arg_count = 4'd10;
      else if (r < 85) c.arg_count = 4'($urandom_range(2, 9));
      else if (r < 95) c.arg_count = 4'($urandom_range(11, 15));
      else c.arg_count = 4'($urandom_range(0, 1));
      for (k = 2; k <= 9; k++) c.arg[k] = 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 40) c.arg[2] = ARG_ON;
      else if (r < 60) c.arg[2] = 8'h00;
      if ($urandom_range(0, 1)) c.arg[3] = EQ_BAND_COUNT;
      if ($urandom_range(0, 2) == 0) c.arg[4] = 8'h00;
      return c;
   endfunction

   function automatic logic [31:0] pick_level();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return 32'd100;
         2: return 32'hffff_ffff;
         3: return $urandom();
         default: return $urandom_range(0, 100);
      endcase
   endfunction

   function automatic logic [31:0] pick_flag();
      if ($urandom_range(0, 99) < 80) return $urandom_range(0, 1);
      return $urandom();
   endfunction

   task automatic predict_reply(input command_type c);
      logic [7:0]     b [0:9];
      logic [7:0]     sub;
      reply_beat_type beat;
      int len;
      int n;
      int k;
      bit power;
      n = 0;
      power = 0;
      len = int'(c.arg_count);
      if (len == 0) return;
      if (len > MAX_LEN) len = MAX_LEN;
      // a one-byte command carries no subtype
      sub = (len > 1) ? c.subtype : ST_NONE;
      b[0] = c.func + 8'd1;
      b[1] = sub;
      case (c.func)
         OP_INIT: begin
            b[1] = ST_NONE;
            n = 2;
         end
         OP_FW_GET: if (sub == ST_TWO) begin
            b[2] = FW_TEXT_LEN;
            for (k = 0; k < 5; k++) b[3 + k] = FW_VERSION[39 - 8 * k -: 8];
            n = 8;
         end
         OP_CAP_GET: if (sub == ST_TWO) begin
            b[2] = CAP_CODE;
            n = 3;
         end
         OP_CODEC_GET: if (sub == ST_NONE) begin
            b[2] = CAP_CODE;
            n = 3;
         end
         OP_BATT_GET: if (sub == ST_NONE) begin
            b[2] = {1'b0, settings.battery_level};
            b[3] = {7'd0, settings.charging_flag};
            n = 4;
         end
         OP_BATT2_GET: begin
            if (settings.legacy_v1_mode) begin
               power = (sub == ST_NONE && len >= 3 && c.arg[2] == ARG_ON);
            end else if (settings.earbuds_mode) begin
               if (sub == ST_EARBUDS) begin
                  b[2] = {1'b0, settings.left_battery};
                  b[3] = {7'd0, settings.charging_flag};
                  b[4] = {1'b0, settings.right_battery};
                  b[5] = {7'd0, settings.charging_flag};
                  n = 6;
               end else if (sub == ST_CASE) begin
                  b[2] = {1'b0, settings.case_battery};
                  b[3] = 8'h00;
                  n = 4;
               end
            end else if (sub == ST_NONE) begin
               b[2] = {1'b0, settings.battery_level};
               b[3] = {7'd0, settings.charging_flag};
               n = 4;
            end
         end
         OP_NOISE_GET: begin
            if (sub == ST_NOISE) begin
               b[2] = 8'h01;
               for (k = 0; k < 4; k++) b[3 + k] = noise_mode[k];
               n = 7;
            end else if (sub == ST_TWO) begin
               b[2] = noise_mode[0];
               b[3] = 8'h01;
               b[4] = (noise_mode[1] == 8'h01) ? 8'h00 : 8'h02;
               b[5] = 8'h01;
               b[6] = noise_mode[2];
               b[7] = noise_mode[3];
               n = 8;
            end
         end
         OP_NOISE_SET: begin
            if (sub == ST_NOISE && len >= 7) begin
               for (k = 0; k < 4; k++) noise_mode[k] = c.arg[3 + k];
               b[2] = 8'h01;
               for (k = 0; k < 4; k++) b[3 + k] = noise_mode[k];
               n = 7;
            end else if (sub == ST_TWO && len >= 8) begin
               noise_mode[0] = c.arg[2];
               noise_mode[1] = (c.arg[2] != 8'h00 && c.arg[4] == 8'h00) ? 8'h01 : 8'h00;
               noise_mode[2] = c.arg[6];
               noise_mode[3] = c.arg[7];
            end
         end
         OP_EQ_GET, OP_EQ_SET: begin
            if (c.func == OP_EQ_SET) begin
               if (len >= 3) eq_preset = c.arg[2];
               if (len >= 10 && c.arg[3] == EQ_BAND_COUNT)
                  for (k = 0; k < 6; k++) eq_bands[k] = c.arg[4 + k];
               b[1] = ST_NONE;
            end
            b[2] = eq_preset;
            b[3] = EQ_BAND_COUNT;
            for (k = 0; k < 6; k++) b[4 + k] = eq_bands[k];
            n = 10;
         end
         OP_DSEE_GET: if (sub == ST_ONE) begin
            b[2] = {7'd0, dsee_enabled};
            n = 3;
         end
         OP_DSEE_SET: if (sub == ST_ONE && len >= 3) dsee_enabled = (c.arg[2] != 8'h00);
         OP_POWER_SET: power = (sub == ST_POWER && len >= 3 && c.arg[2] == ARG_ON);
         OP_AUTO_OFF_GET: if (sub == ST_AUTO_OFF) begin
            b[2] = auto_off[0];
            b[3] = auto_off[1];
            n = 4;
         end
         OP_AUTO_OFF_SET: if (sub == ST_AUTO_OFF && len >= 4) begin
            auto_off[0] = c.arg[2];
            auto_off[1] = c.arg[3];
         end
         OP_MISC_GET: begin
            if (sub == ST_STC) begin
               b[2] = {7'd0, !chat_enabled};
               n = 3;
            end else if (sub == ST_CASE) begin
               b[2] = {7'd0, !adaptive_enabled};
               n = 3;
            end
         end
         OP_MISC_SET: if (len >= 3) begin
            if (sub == ST_STC) chat_enabled = (c.arg[2] == 8'h00);
            if (sub == ST_CASE) adaptive_enabled = (c.arg[2] == 8'h00);
         end
         default: ;
      endcase
      if (power) begin
         beat = '{data: 8'h00, last: 1'b1, seq: 1'b0, power_off: 1'b1};
         replies_due.push_back(beat);
      end else if (n > 0) begin
         for (k = 0; k < n; k++) begin
            beat = '{data: b[k], last: (k == n - 1), seq: reply_seq, power_off: 1'b0};
            replies_due.push_back(beat);
         end
         reply_seq = !reply_seq;
      end
   endtask

   // request driver
   always @(negedge clock) begin : drive_requests
      command_type upcoming;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (hold_left > 0) begin
            hold_left--;
            req_valid <= 1'b0;
         end else if (pending.size() > 0) begin
            upcoming = pending.pop_front();
            req_func <= upcoming.func;
            req_subtype <= upcoming.subtype;
            req_arg_count <= upcoming.arg_count;
            req_arg2 <= upcoming.arg[2];
            req_arg3 <= upcoming.arg[3];
            req_arg4 <= upcoming.arg[4];
            req_arg5 <= upcoming.arg[5];
            req_arg6 <= upcoming.arg[6];
            req_arg7 <= upcoming.arg[7];
            req_arg8 <= upcoming.arg[8];
            req_arg9 <= upcoming.arg[9];
            req_valid <= 1'b1;
            requests_sent++;
            hold_left = req_idling ? pick_gap() : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // reply side back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_idling && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
   end

   // monitor: predict on accepted requests, compare reply bytes
   always @(posedge clock) begin : watch_ports
      command_type    seen;
      reply_beat_type due;
      req_accepted = 0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            seen.func = req_func;
            seen.subtype = req_subtype;
            seen.arg_count = req_arg_count;
            seen.arg = {req_arg2, req_arg3, req_arg4, req_arg5,
                        req_arg6, req_arg7, req_arg8, req_arg9};
            predict_reply(seen);
            requests_taken++;
            req_accepted = 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (replies_due.size() == 0) begin
               $error("unexpected reply: byte %h last %b seq %b power_off %b", rsp_reply_byte,
                      rsp_reply_last, rsp_reply_sequence, rsp_power_off);
               error_count++;
            end else begin
               due = replies_due.pop_front();
               if (rsp_reply_byte !== due.data) begin
                  $error("reply_byte: expected %h, got %h", due.data, rsp_reply_byte);
                  error_count++;
               end
               if (rsp_reply_last !== due.last) begin
                  $error("reply_last: expected %b, got %b", due.last, rsp_reply_last);
                  error_count++;
               end
               if (rsp_reply_sequence !== due.seq) begin
                  $error("reply_sequence: expected %b, got %b", due.seq, rsp_reply_sequence);
                  error_count++;
               end
               if (rsp_power_off !== due.power_off) begin
                  $error("power_off: expected %b, got %b", due.power_off, rsp_power_off);
                  error_count++;
               end
            end
         end
      end
   end

   // hold off until all requests are in and every reply byte is out
   task automatic wait_quiet();
      do @(negedge clock);
      while (pending.size() != 0 || requests_sent != requests_taken || replies_due.size() != 0);
      // commands without a reply may still be in flight
      repeat (12) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         REG_EARBUDS: settings.earbuds_mode = value[0];
         REG_LEGACY: settings.legacy_v1_mode = value[0];
         REG_BATTERY: settings.battery_level = value[6:0];
         REG_CHARGING: settings.charging_flag = value[0];
         REG_LEFT: settings.left_battery = value[6:0];
         REG_RIGHT: settings.right_battery = value[6:0];
         REG_CASE: settings.case_battery = value[6:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   initial begin
      int phase;
      int k;
      settings = '{earbuds_mode: 1'b0, legacy_v1_mode: 1'b0, battery_level: 7'd100,
                   charging_flag: 1'b0, left_battery: 7'd100, right_battery: 7'd100,
                   case_battery: 7'd100};
      for (k = 0; k < 4; k++) noise_mode[k] = 8'h00;
      for (k = 0; k < 6; k++) eq_bands[k] = 8'h00;
      eq_preset = 8'h00;
      auto_off[0] = 8'h00;
      auto_off[1] = 8'h00;
      dsee_enabled = 1'b0;
      chat_enabled = 1'b0;
      adaptive_enabled = 1'b0;
      reply_seq = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed commands at reset settings, back to back
      pending.push_back(command(OP_INIT, ST_NONE, 4'd1, '0));
      pending.push_back(command(OP_INIT, ST_UNUSED, 4'd0, '1));
      pending.push_back(command(OP_UNUSED, ST_UNUSED, 4'd15, '1));
      pending.push_back(command(OP_FW_GET, ST_TWO, 4'd2, '0));
      pending.push_back(command(OP_FW_GET, ST_TWO, 4'd1, '0));
      pending.push_back(command(OP_CAP_GET, ST_TWO, 4'd10, '1));
      pending.push_back(command(OP_CODEC_GET, ST_UNUSED, 4'd1, '0));
      pending.push_back(command(OP_BATT_GET, ST_NONE, 4'd2, '0));
      pending.push_back(command(OP_BATT2_GET, ST_NONE, 4'd3, 64'h01ff_ffff_ffff_ffff));
      pending.push_back(command(OP_NOISE_SET, ST_NOISE, 4'd7, 64'h0011_2233_4400_0000));
      pending.push_back(command(OP_NOISE_GET, ST_NOISE, 4'd2, '0));
      pending.push_back(command(OP_NOISE_SET, ST_TWO, 4'd8, 64'h05ff_00ff_0709_ffff));
      pending.push_back(command(OP_NOISE_GET, ST_TWO, 4'd2, '0));
      pending.push_back(command(OP_EQ_SET, ST_NONE, 4'd10, 64'h0306_f6fb_0005_0aff));
      pending.push_back(command(OP_EQ_GET, ST_UNUSED, 4'd2, '0));
      pending.push_back(command(OP_EQ_SET, ST_NONE, 4'd3, 64'h8006_0101_0101_0101));
      pending.push_back(command(OP_DSEE_SET, ST_ONE, 4'd3, 64'h8000_0000_0000_0000));
      pending.push_back(command(OP_DSEE_GET, ST_ONE, 4'd2, '0));
      pending.push_back(command(OP_POWER_SET, ST_POWER, 4'd3, 64'h0100_0000_0000_0000));
      pending.push_back(command(OP_POWER_SET, ST_POWER, 4'd2, 64'h0100_0000_0000_0000));
      pending.push_back(command(OP_AUTO_OFF_SET, ST_AUTO_OFF, 4'd4, 64'hff00_0000_0000_0000));
      pending.push_back(command(OP_AUTO_OFF_GET, ST_AUTO_OFF, 4'd2, '0));
      pending.push_back(command(OP_MISC_SET, ST_STC, 4'd3, '0));
      pending.push_back(command(OP_MISC_GET, ST_STC, 4'd2, '0));
      pending.push_back(command(OP_MISC_SET, ST_CASE, 4'd3, '0));
      pending.push_back(command(OP_MISC_GET, ST_CASE, 4'd2, '0));
      pending.push_back(command(OP_NOISE_GET, ST_UNUSED, 4'd2, '0));
      wait_quiet();

      // earbuds battery report with extreme levels
      csr_write(REG_EARBUDS, 32'd1);
      csr_write(REG_BATTERY, 32'd0);
      csr_write(REG_CHARGING, 32'd1);
      csr_write(REG_LEFT, 32'd0);
      csr_write(REG_RIGHT, 32'hffff_ffff);
      csr_write(REG_CASE, 32'd100);
      pending.push_back(command(OP_BATT2_GET, ST_EARBUDS, 4'd2, '0));
      pending.push_back(command(OP_BATT2_GET, ST_CASE, 4'd2, '0));
      pending.push_back(command(OP_BATT2_GET, ST_NONE, 4'd2, '0));
      pending.push_back(command(OP_BATT_GET, ST_NONE, 4'd2, '0));
      wait_quiet();

      // legacy mode turns the battery opcode into power-off
      csr_write(REG_LEGACY, 32'd1);
      pending.push_back(command(OP_BATT2_GET, ST_NONE, 4'd3, 64'h0100_0000_0000_0000));
      pending.push_back(command(OP_BATT2_GET, ST_NONE, 4'd3, '0));
      pending.push_back(command(OP_BATT2_GET, ST_EARBUDS, 4'd2, '0));
      wait_quiet();

      for (phase = 0; phase < 6; phase++) begin
         csr_write(REG_EARBUDS, pick_flag());
         csr_write(REG_LEGACY, ($urandom_range(0, 2) == 0) ? pick_flag() : 32'd0);
         csr_write(REG_BATTERY, pick_level());
         csr_write(REG_CHARGING, pick_flag());
         csr_write(REG_LEFT, pick_level());
         csr_write(REG_RIGHT, pick_level());
         csr_write(REG_CASE, pick_level());
         req_idling = (phase % 3 != 1);
         rsp_idling = (phase % 3 != 2);
         for (k = 0; k < 30; k++) pending.push_back(random_command());
         // sender pauses mid-phase until the replies have drained
         wait_quiet();
         for (k = 0; k < 30; k++) pending.push_back(random_command());
         wait_quiet();
      end

      if (error_count == 0) begin
         $display("headset_command_responder_unit test passed");
      end else begin
         $display("headset_command_responder_unit test failed");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("headset_command_responder_unit test failed");
      $finish;
   end

endmodule

FILE: headset_command_responder_unit.f
src/hcr_pkg.sv
src/hcr_front.sv
src/hcr_queue.sv
src/hcr_back.sv
src/headset_command_responder_unit.sv
bench/headset_command_responder_unit_test.sv
